/* rtl/core/fbc_pkg.sv */
// Package for the two-round Feistel byte cipher: permutation tables, S-boxes,
// the key schedule and round helper functions, and shared types.
// No dependencies.
package fbc_pkg;

  localparam int unsigned KeyW   = 10;
  localparam int unsigned BlockW = 8;

  localparam logic [KeyW-1:0] KeyReset = 10'd255;

  // S-boxes: index is {row, col}, row = {n[3], n[0]}, col = n[2:1].
  localparam logic [1:0] SBOX_A [16] = '{
    2'd1, 2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd0, 2'd2,
    2'd2, 2'd0, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2, 2'd0
  };
  localparam logic [1:0] SBOX_B [16] = '{
    2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1,
    2'd1, 2'd0, 2'd3, 2'd2, 2'd2, 2'd1, 2'd3, 2'd0
  };

  // Permutation tables list source bit positions counted from the MSB.
  localparam logic [1:0] EXPAND [8]  = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [1:0] PERM4  [4]  = '{2'd1, 2'd0, 2'd3, 2'd2};
  localparam logic [3:0] PERM10 [10] = '{4'd9, 4'd7, 4'd3, 4'd8, 4'd0,
                                         4'd2, 4'd6, 4'd5, 4'd1, 4'd4};
  localparam logic [2:0] PERM8  [8]  = '{3'd3, 3'd1, 3'd7, 3'd5, 3'd0, 3'd6, 3'd4, 3'd2};

  typedef struct packed {
    logic [BlockW-1:0] k1;
    logic [BlockW-1:0] k2;
  } subkeys_t;

  function automatic logic [9:0] perm10(input logic [9:0] v);
    logic [9:0] r;
    r = '0;
    for (int j = 0; j < 10; j++) begin
      r[9-j] = v[4'd9 - PERM10[j]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm8(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      r[7-j] = v[3'd7 - PERM8[j]];
    end
    return r;
  endfunction

  function automatic logic [7:0] expand(input logic [3:0] v);
    logic [7:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      r[7-j] = v[2'd3 - EXPAND[j]];
    end
    return r;
  endfunction

  function automatic logic [3:0] perm4(input logic [3:0] v);
    logic [3:0] r;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      r[3-j] = v[2'd3 - PERM4[j]];
    end
    return r;
  endfunction

  function automatic logic [1:0] sbox_a(input logic [3:0] n);
    return SBOX_A[{n[3], n[0], n[2:1]}];
  endfunction

  function automatic logic [1:0] sbox_b(input logic [3:0] n);
    return SBOX_B[{n[3], n[0], n[2:1]}];
  endfunction

  // Expansion, subkey mix and both S-boxes; P4 follows in the next stage.
  function automatic logic [3:0] sbox_layer(input logic [3:0] right,
                                             input logic [7:0] subkey);
    logic [7:0] x;
    x = expand(right) ^ subkey;
    return {sbox_a(x[7:4]), sbox_b(x[3:0])};
  endfunction

  // Both subkeys from the master key. Rotations are fixed wiring.
  function automatic subkeys_t key_schedule(input logic [9:0] key);
    logic [9:0] p;
    logic [4:0] hi1, lo1, hi3, lo3;
    subkeys_t   s;
    p     = perm10(key);
    hi1   = {p[8:5], p[9]};
    lo1   = {p[3:0], p[4]};
    hi3   = {hi1[2:0], hi1[4:3]};
    lo3   = {lo1[2:0], lo1[4:3]};
    s.k1  = perm8({hi1[2:0], lo1});
    s.k2  = perm8({hi3[2:0], lo3});
    return s;
  endfunction

endpackage

/* rtl/core/fbc_if.sv */
// Valid/ready channel interfaces for the byte cipher: plaintext in, result out.
// Depends on fbc_pkg for field widths.
interface fbc_in_if;
  logic                          valid;
  logic                          ready;
  logic [fbc_pkg::BlockW-1:0]    plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink   (input valid, input plaintext, output ready);
endinterface

interface fbc_out_if;
  logic                          valid;
  logic                          ready;
  logic [fbc_pkg::BlockW-1:0]    ciphertext;
  logic [fbc_pkg::BlockW-1:0]    round_one_out;

  modport source (output valid, output ciphertext, output round_one_out, input ready);
  modport sink   (input valid, input ciphertext, input round_one_out, output ready);
endinterface

/* rtl/core/two_round_feistel_byte_cipher_unit.sv */
// Top level of the two-round Feistel byte cipher.
// Depends on fbc_pkg, fbc_if, fbc_key_sched and fbc_datapath.
//
// Usage:
//   plain_i  - sink channel; one beat carries an 8-bit plaintext block.
//   cipher_o - source channel; one beat per plaintext carries the ciphertext
//              (after round two, halves not swapped) and round_one_out (the
//              block after round one, halves swapped).
//   cfg_we_i / cfg_wdata_i - write the 10-bit master key. Write only while
//              the pipeline is empty; both subkeys are derived and registered
//              at the write, so a new key applies from the next beat.
// Path: an accepted input beat passes the stage one, stage two and output
// registers to cipher_o. Throughput: one beat per cycle while cipher_o.ready is
// high; the three pipeline stages (round one S-boxes, round one mix plus round
// two S-boxes, round two mix) each take a new block every cycle unless stalled.
// Reset: all stage valids clear, the pipeline is empty and the key is 255.
// Stall: when cipher_o.ready is low the output register holds its beat;
// empty stages behind it keep filling, and plain_i.ready drops only once
// every stage holds a beat. Nothing is lost or repeated.
module two_round_feistel_byte_cipher_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fbc_pkg::KeyW-1:0]  cfg_wdata_i,
  fbc_in_if.sink                    plain_i,
  fbc_out_if.source                 cipher_o
);

  fbc_pkg::subkeys_t subkeys;

  // Key register and schedule; subkeys are stable between writes.
  fbc_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .subkeys_o   (subkeys)
  );

  // Round pipeline with per-stage valids and a ready chain.
  fbc_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .subkeys_i (subkeys),
    .in_i      (plain_i),
    .out_o     (cipher_o)
  );

endmodule

/* rtl/core/fbc_key_sched.sv */
// Key register and subkey schedule for the byte cipher.
// Depends on fbc_pkg (key_schedule, subkeys_t).
module fbc_key_sched (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fbc_pkg::KeyW-1:0]   cfg_wdata_i,
  output fbc_pkg::subkeys_t          subkeys_o
);

  fbc_pkg::subkeys_t subkeys_d, subkeys_q;

  // Derive the subkeys once, at the write.
  always_comb begin
    subkeys_d = subkeys_q;
    if (cfg_we_i) begin
      subkeys_d = fbc_pkg::key_schedule(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subkeys_q <= fbc_pkg::key_schedule(fbc_pkg::KeyReset);
    end else begin
      subkeys_q <= subkeys_d;
    end
  end

  assign subkeys_o = subkeys_q;

endmodule

/* rtl/core/fbc_datapath.sv */
// Three-stage pipeline of the two Feistel rounds with valid/ready flow control.
// Depends on fbc_pkg and the fbc_in_if / fbc_out_if interfaces.
module fbc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbc_pkg::subkeys_t  subkeys_i,
  fbc_in_if.sink             in_i,
  fbc_out_if.source          out_o
);

  // Stage valids and advance enables.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  // Stage 1: round one S-box output and the block.
  logic [7:0] blk1_q;
  logic [3:0] s1_q;
  // Stage 2: round one result (swapped) and round two S-box output.
  logic [7:0] first2_q, first2_d;
  logic [3:0] s2_q, s2_d;
  logic [3:0] mix1;
  // Stage 3: output register.
  logic [7:0] ct3_q, ct3_d;
  logic [7:0] r1_3_q;

  assign adv3 = !v3_q || out_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_i.ready = adv1;

  always_comb begin
    mix1     = fbc_pkg::perm4(s1_q) ^ blk1_q[7:4];
    first2_d = {blk1_q[3:0], mix1};
    s2_d     = fbc_pkg::sbox_layer(first2_d[3:0], subkeys_i.k2);
    ct3_d    = {fbc_pkg::perm4(s2_q) ^ first2_q[7:4], first2_q[3:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload moves only with a valid beat; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) begin
      blk1_q <= in_i.plaintext;
      s1_q   <= fbc_pkg::sbox_layer(in_i.plaintext[3:0], subkeys_i.k1);
    end
    if (adv2 && v1_q) begin
      first2_q <= first2_d;
      s2_q     <= s2_d;
    end
    if (adv3 && v2_q) begin
      ct3_q  <= ct3_d;
      r1_3_q <= first2_q;
    end
  end

  assign out_o.valid         = v3_q;
  assign out_o.ciphertext    = ct3_q;
  assign out_o.round_one_out = r1_3_q;

endmodule

/* rtl/core/fbc_checker.sv */
// Port-level checks for the byte cipher top level, attached with bind.
// Depends on two_round_feistel_byte_cipher_unit and fbc_pkg.
module fbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [fbc_pkg::BlockW-1:0]  ciphertext_i,
  input logic [fbc_pkg::BlockW-1:0]  round_one_out_i
);

  // A stalled result beat stays and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ciphertext_i)
      && $stable(round_one_out_i))
    else $error("result beat dropped or changed under stall");

  // No result beat while in reset.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // A receiver that takes results never backs up the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output ready");

  // With the output free, an accepted beat passes stages two and three and shows up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after pipeline latency");

endmodule

bind two_round_feistel_byte_cipher_unit fbc_checker u_fbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (plain_i.valid),
  .in_ready_i      (plain_i.ready),
  .out_valid_i     (cipher_o.valid),
  .out_ready_i     (cipher_o.ready),
  .ciphertext_i    (cipher_o.ciphertext),
  .round_one_out_i (cipher_o.round_one_out)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for two_round_feistel_byte_cipher_unit: drives plaintext
// beats and key writes, predicts both rounds locally and scores every result beat.
// Depends on fbc_pkg, fbc_if and two_round_feistel_byte_cipher_unit from the RTL tree.
module testbench;

  // Pipeline depth from input beat to result beat.
  localparam int PipeDepth  = 3;
  // Length of the long receiver hold-off, in cycles.
  localparam int LongHold   = 60;
  // Hard stop; a correct run needs only a small fraction of this.
  localparam int CycleLimit = 200_000;

  // Cipher tables packed one entry per field, entry 0 in the lowest field.
  // Permutation entries are 4 bits wide and name a source bit from the MSB.
  localparam logic [39:0] KeyPermTab  = 40'h4156208379;  // 10 -> 10
  localparam logic [39:0] SubPermTab  = 40'h0024605713;  // 8 -> 8
  localparam logic [39:0] ExpandTab   = 40'h0003212103;  // 4 -> 8
  localparam logic [39:0] MixPermTab  = 40'h0000002301;  // 4 -> 4
  // S-box entries are 2 bits wide, indexed by {row, col}.
  localparam logic [31:0] SubstHiTab  = 32'h2D7287E1;
  localparam logic [31:0] SubstLoTab  = 32'h36B14B9C;

  typedef struct packed {
    logic [fbc_pkg::BlockW-1:0] ciphertext;
    logic [fbc_pkg::BlockW-1:0] round_one_out;
  } cipher_beat_t;

  // Holds the key shadow and the expected result beats in order.
  class cipher_scoreboard;
    logic [fbc_pkg::KeyW-1:0] key;
    cipher_beat_t             expected_q[$];
    int unsigned              errors;

    function new();
      key    = fbc_pkg::KeyReset;
      errors = 0;
    endfunction

    function logic [9:0] shuffle(logic [9:0] v, int n_in, int n_out, logic [39:0] tbl);
      logic [9:0] r;
      int         src;
      r = '0;
      for (int j = 0; j < n_out; j++) begin
        src = int'(tbl[4*j +: 4]);
        r[n_out-1-j] = v[n_in-1-src];
      end
      return r;
    endfunction

    function logic [4:0] rotl5(logic [4:0] x, int s);
      logic [9:0] w;
      w = {x, x};
      return w[9-s -: 5];
    endfunction

    function logic [1:0] subst(logic [31:0] box, logic [3:0] n);
      logic [3:0] idx;
      idx = {n[3], n[0], n[2:1]};
      return box[2*idx +: 2];
    endfunction

    function logic [3:0] round_mix(logic [3:0] right, logic [7:0] subkey);
      logic [7:0] x;
      x = 8'(shuffle(10'(right), 4, 8, ExpandTab)) ^ subkey;
      return 4'(shuffle(10'({subst(SubstHiTab, x[7:4]), subst(SubstLoTab, x[3:0])}),
                        4, 4, MixPermTab));
    endfunction

    function cipher_beat_t encrypt(logic [7:0] pt);
      logic [9:0]   p;
      logic [4:0]   hi, lo;
      logic [7:0]   sub_one, sub_two, mixed, swapped;
      cipher_beat_t r;
      p       = shuffle(key, 10, 10, KeyPermTab);
      hi      = rotl5(p[9:5], 1);
      lo      = rotl5(p[4:0], 1);
      sub_one = 8'(shuffle(10'({hi[2:0], lo}), 8, 8, SubPermTab));
      hi      = rotl5(hi, 2);
      lo      = rotl5(lo, 2);
      sub_two = 8'(shuffle(10'({hi[2:0], lo}), 8, 8, SubPermTab));
      mixed   = {round_mix(pt[3:0], sub_one) ^ pt[7:4], pt[3:0]};
      swapped = {mixed[3:0], mixed[7:4]};
      r.round_one_out = swapped;
      r.ciphertext    = {round_mix(swapped[3:0], sub_two) ^ swapped[7:4], swapped[3:0]};
      return r;
    endfunction

    function void set_key(logic [fbc_pkg::KeyW-1:0] k);
      key = k;
    endfunction

    function void note_plaintext(logic [7:0] pt);
      expected_q.push_back(encrypt(pt));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void check_result(logic [7:0] ct, logic [7:0] r1);
      cipher_beat_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat ciphertext=%02h round_one_out=%02h",
                 $time, ct, r1);
        return;
      end
      want = expected_q.pop_front();
      if (ct !== want.ciphertext) begin
        errors++;
        $display("%0t: ciphertext expected %02h actual %02h", $time, want.ciphertext, ct);
      end
      if (r1 !== want.round_one_out) begin
        errors++;
        $display("%0t: round_one_out expected %02h actual %02h",
                 $time, want.round_one_out, r1);
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [fbc_pkg::KeyW-1:0] cfg_wdata_i;

  fbc_in_if  plain_if ();
  fbc_out_if cipher_if ();

  cipher_scoreboard sb = new();

  // Idle odds in percent per cycle, set per phase by the stimulus.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // Long hold-off handshake: stimulus bumps hold_asked, receiver serves it.
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int cycles      = 0;

  two_round_feistel_byte_cipher_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .plain_i     (plain_if),
    .cipher_o    (cipher_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when one is asked for.
  // The hold counts down in this process so the sender keeps pushing and the
  // pipeline fills until plain_i.ready drops.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_if.ready <= 1'b0;
      hold_left       <= 0;
      hold_served     <= 0;
    end else if (hold_left != 0) begin
      cipher_if.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      cipher_if.ready <= 1'b0;
      hold_left       <= LongHold;
      hold_served     <= hold_asked;
    end else begin
      cipher_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Score each result beat at the edge that accepts it; also guard the run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && cipher_if.valid && cipher_if.ready) begin
      sb.check_result(cipher_if.ciphertext, cipher_if.round_one_out);
    end
    if (cycles >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offer one plaintext beat and hold it until accepted. Idle cycle by cycle
  // first, at the sender's odds, so gaps land on every pipeline phase.
  task automatic send_block(input logic [7:0] pt);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      plain_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    plain_if.valid     <= 1'b1;
    plain_if.plaintext <= pt;
    do @(posedge clk_i); while (!plain_if.ready);
    sb.note_plaintext(pt);
  endtask

  // Drop valid and wait until every expected beat is back, then let the
  // pipeline run dry.
  task automatic settle();
    plain_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  // Write the master key with the pipeline empty; it applies to the next beat.
  task automatic write_key(input logic [fbc_pkg::KeyW-1:0] k);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_key(k);
  endtask

  task automatic encrypt_burst(input int n);
    for (int i = 0; i < n; i++) send_block(8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0] corners[$];
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    plain_if.valid     <= 1'b0;
    plain_if.plaintext <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key first, with all-zero, all-one, nibble, alternating and single-bit blocks.
    corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h01, 8'h80};
    foreach (corners[i]) send_block(corners[i]);

    // Key extremes and alternating key patterns.
    write_key(10'h000);
    send_block(8'h00);
    send_block(8'hFF);
    send_block(8'h5A);
    write_key(10'h3FF);
    send_block(8'h00);
    send_block(8'hFF);
    send_block(8'hA5);
    write_key(10'h2AA);
    send_block(8'h3C);
    write_key(10'h155);
    send_block(8'hC3);

    // Random: sender-light / receiver-heavy idling.
    tx_idle_pct = 35;
    rx_idle_pct = 64;
    write_key(10'($urandom_range(1023)));
    encrypt_burst(65);
    write_key(10'($urandom_range(1023)));
    encrypt_burst(65);

    // Swap the idle odds.
    tx_idle_pct = 64;
    rx_idle_pct = 35;
    write_key(10'($urandom_range(1023)));
    encrypt_burst(65);
    write_key(10'($urandom_range(1023)));
    encrypt_burst(65);

    // No idling; hold the receiver off for a long stretch so the pipeline
    // backs up, then pause the sender until everything has drained.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_key(10'($urandom_range(1023)));
    hold_asked <= hold_asked + 1;
    encrypt_burst(40);
    settle();
    encrypt_burst(25);
    write_key(10'($urandom_range(1023)));
    encrypt_burst(65);

    settle();
    repeat (2 * PipeDepth) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d result beats never arrived",
                                      $time, sb.pending());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fbc_pkg.sv
rtl/core/fbc_if.sv
rtl/core/fbc_key_sched.sv
rtl/core/fbc_datapath.sv
rtl/core/two_round_feistel_byte_cipher_unit.sv
rtl/core/fbc_checker.sv
dv/testbench.sv
